>>> hw/rtl/tssc_pkg.sv
// Shared types, constants and saturating helpers for the two-segment spring chain step block.
// Used by tssc_sqdiv and two_segment_spring_chain_step_top. No dependencies.
package tssc_pkg;

  // Fraction bits of positions, velocities, gains and directions.
  localparam int FRAC_BITS = 16;
  // Fraction bits of the time step.
  localparam int DT_BITS   = 16;

  localparam int RAD_W  = 64;             // sum of three squares
  localparam int ROOT_W = 33;             // floor square root of that sum
  localparam int DIR_W  = FRAC_BITS + 2;  // unit direction component
  localparam int QUOT_W = FRAC_BITS + 1;  // magnitude of a direction component

  typedef enum logic [2:0] {
    CFG_SPRING_GAIN = 3'd0,
    CFG_TORQUE_GAIN = 3'd1,
    CFG_DRAG_RATE   = 3'd2,
    CFG_REST_LENGTH = 3'd3,
    CFG_GRAVITY_X   = 3'd4,
    CFG_GRAVITY_Y   = 3'd5,
    CFG_GRAVITY_Z   = 3'd6
  } cfg_idx_e;

  // Request to the shared root and divide unit.
  typedef struct packed {
    logic start;
    logic div;     // 1: divide, 0: square root
  } sd_req_t;

  // Answer of the shared root and divide unit.
  typedef struct packed {
    logic                     done;
    logic [ROOT_W-1:0]        root;
    logic signed [DIR_W-1:0]  quot;
  } sd_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] r;
    if (v > 68'sd2147483647) begin
      r = 32'sh7fff_ffff;
    end else if (v < -68'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    logic signed [31:0] r;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      r = s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    logic signed [31:0] r;
    s = {a[31], a} - {b[31], b};
    if (s[32] != s[31]) begin
      r = s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/tssc_sqdiv.sv
// Shared iterative unit: floor square root of a 64-bit sum, or a signed component
// divided by a length into a unit direction. Depends on tssc_pkg.
module tssc_sqdiv (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tssc_pkg::sd_req_t                   req_i,
  input  logic [tssc_pkg::RAD_W-1:0]          rad_i,
  input  logic signed [31:0]                  num_i,
  input  logic [tssc_pkg::ROOT_W-1:0]         den_i,
  output tssc_pkg::sd_rsp_t                   rsp_o
);

  logic                          busy_q, done_q, div_q, neg_q, nb_q;
  logic [4:0]                    cnt_q;
  logic [63:0]                   v_q, r_q;
  logic [tssc_pkg::ROOT_W-1:0]   den_q;

  logic [32:0] mag;
  logic [63:0] bitv, minu, subt;
  logic [64:0] diff;
  logic        ge, nbit;

  assign mag  = num_i[31] ? (33'd0 - {num_i[31], num_i}) : {1'b0, num_i};
  assign bitv = 64'd1 << {cnt_q, 1'b0};
  assign nbit = (cnt_q == 5'(tssc_pkg::QUOT_W - 1)) ? nb_q : 1'b0;

  // One compare-subtract serves both operations.
  always_comb begin
    if (div_q) begin
      minu = {30'd0, v_q[32:0], nbit};
      subt = {31'd0, den_q};
    end else begin
      minu = v_q;
      subt = r_q + bitv;
    end
    diff = {1'b0, minu} - {1'b0, subt};
    ge   = !diff[64];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      div_q  <= 1'b0;
      neg_q  <= 1'b0;
      nb_q   <= 1'b0;
      cnt_q  <= '0;
      v_q    <= '0;
      r_q    <= '0;
      den_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        div_q  <= req_i.div;
        r_q    <= '0;
        den_q  <= den_i;
        neg_q  <= num_i[31];
        nb_q   <= mag[0];
        if (req_i.div) begin
          v_q   <= {32'd0, mag[32:1]};
          cnt_q <= 5'(tssc_pkg::QUOT_W - 1);
        end else begin
          v_q   <= rad_i;
          cnt_q <= 5'd31;
        end
      end else if (busy_q) begin
        if (div_q) begin
          v_q <= ge ? diff[63:0] : minu;
          r_q <= {r_q[62:0], ge};
        end else if (ge) begin
          v_q <= diff[63:0];
          r_q <= (r_q >> 1) + bitv;
        end else begin
          r_q <= r_q >> 1;
        end
        if (cnt_q == 5'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 5'd1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.root = r_q[tssc_pkg::ROOT_W-1:0];
  assign rsp_o.quot = neg_q ? (tssc_pkg::DIR_W'(0) - {1'b0, r_q[tssc_pkg::QUOT_W-1:0]})
                            : {1'b0, r_q[tssc_pkg::QUOT_W-1:0]};

endmodule

>>> hw/rtl/two_segment_spring_chain_step_top.sv
// Top level of the two-segment spring chain step block: sequencer, state, shared multiplier.
// Depends on tssc_pkg and tssc_sqdiv.
//
//   Channel | Direction | Signals                     | One beat carries
//   --------+-----------+-----------------------------+--------------------------------------
//   s_axis  | in        | tvalid, tready, tdata, tuser| base point, base direction, time step
//   m_axis  | out       | tvalid, tready, tdata       | mid and tip positions after the item
//   cfg     | in        | we, idx, data               | one gain, length or gravity register
//
// A reset beat (tuser high) needs three products and no root or division. In an advance
// beat, four segment lengths each need a square root and three divisions in the shared
// root and divide unit, and 55 products go one by one through the shared multiplier.
// A zero-length segment skips its divisions.
// s_axis_tready_o is high only while the sequencer is idle. A finished result sits in the
// output register until taken, and the next beat may be accepted meanwhile; its result
// waits at the end of its sequence until the output register is free.
// Reset clears the strand state to zero and loads the register defaults.
module two_segment_spring_chain_step_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  // base_x[31:0], base_y[63:32], base_z[95:64], dir_x[113:96], dir_y[131:114],
  // dir_z[149:132], delta_time[165:150], zeros[167:166]
  input  logic [167:0]  s_axis_tdata_i,
  // mode[0]
  input  logic          s_axis_tuser_i,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // mid_x[31:0], mid_y[63:32], mid_z[95:64], tip_x[127:96], tip_y[159:128], tip_z[191:160]
  output logic [191:0]  m_axis_tdata_o,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [31:0]   cfg_data_i
);

  localparam int DW = tssc_pkg::DIR_W;

  typedef enum logic [3:0] {
    S_IDLE, S_RST, S_DIFF, S_SQ, S_ROOT_GO, S_ROOT_WAIT, S_DIV_GO, S_DIV_WAIT,
    S_SEG_END, S_VEL, S_MOM, S_DRAG, S_PROJ, S_DONE
  } state_e;

  // Order of the products in the velocity update of one component.
  typedef enum logic [3:0] {
    V_MSPR, V_MGAIN, V_MDT, V_TSPR, V_TGAIN, V_TDT, V_MTQ, V_MTQDT, V_TTQ, V_TTQDT
  } vstep_e;

  state_e  state_q;
  vstep_e  step_q;
  logic [1:0] idx_q, seg_q;
  logic       phase_q, sub_q, out_valid_q;

  logic [23:0]        sg_q, tg_q, drag_q, rest_q;
  logic signed [31:0] grav_q [3];
  logic signed [31:0] mp_q [3], tp_q [3], mv_q [3], tv_q [3];
  logic signed [31:0] base_q [3];
  logic signed [DW-1:0] bdir_q [3], md_q [3], ed_q [3];
  logic [15:0]        dt_q;
  logic signed [31:0] ax_q [3];
  logic [63:0]        acc_q;
  logic [tssc_pkg::ROOT_W-1:0] root_q;
  logic signed [35:0] mf2_q, ef2_q, f2;
  logic signed [31:0] t_q;
  logic signed [DW-1:0] mom_q;
  logic               mom_neg_q;
  logic [191:0]       out_q;

  logic signed [35:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [67:0] prod_q;
  logic signed [31:0] r16, r17, dv;
  logic signed [25:0] mom_w;

  tssc_pkg::sd_req_t sd_req;
  tssc_pkg::sd_rsp_t sd_rsp;

  tssc_sqdiv u_sqdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sd_req),
    .rad_i  (acc_q),
    .num_i  (ax_q[idx_q]),
    .den_i  (root_q),
    .rsp_o  (sd_rsp)
  );

  // The divisor is the root kept from the last square root; the unit latches it at each start.
  assign sd_req.start = (state_q == S_ROOT_GO) || (state_q == S_DIV_GO);
  assign sd_req.div   = (state_q == S_DIV_GO);

  // Operand selection for the one shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_RST: begin
        mul_a = 36'(bdir_q[idx_q]);
        mul_b = 32'(rest_q);
      end
      S_SQ: begin
        mul_a = 36'(ax_q[idx_q]);
        mul_b = ax_q[idx_q];
      end
      S_VEL: begin
        case (step_q)
          V_MSPR:  begin mul_a = mf2_q;              mul_b = 32'(md_q[idx_q]);   end
          V_TSPR:  begin mul_a = ef2_q;              mul_b = 32'(ed_q[idx_q]);   end
          V_MGAIN, V_TGAIN: begin mul_a = 36'(t_q);  mul_b = 32'(sg_q);          end
          V_MTQ:   begin mul_a = 36'(bdir_q[idx_q]); mul_b = 32'(tg_q);          end
          V_TTQ:   begin mul_a = 36'(md_q[idx_q]);   mul_b = 32'(tg_q);          end
          default: begin mul_a = 36'(t_q);           mul_b = 32'(dt_q);          end
        endcase
      end
      S_MOM: begin
        mul_a = 36'(drag_q);
        mul_b = 32'(dt_q);
      end
      S_DRAG: begin
        mul_a = sub_q ? 36'(tv_q[idx_q]) : 36'(mv_q[idx_q]);
        mul_b = 32'(mom_q);
      end
      S_PROJ: begin
        mul_a = sub_q ? 36'(md_q[idx_q]) : 36'(ed_q[idx_q]);
        mul_b = 32'(rest_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // Floor shifts with saturation; the extra bit carries half the rest length.
  assign r16   = tssc_pkg::sat32(prod_q >>> tssc_pkg::FRAC_BITS);
  assign r17   = tssc_pkg::sat32(prod_q >>> (tssc_pkg::FRAC_BITS + 1));
  assign mom_w = 26'sd65536 - $signed({2'b00, prod_q[39:16]});
  assign dv    = mom_neg_q ? 32'sd0 : r16;
  assign f2    = $signed(36'({sd_rsp.root, 1'b0})) - $signed(36'(rest_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= V_MSPR;
      idx_q       <= '0;
      seg_q       <= '0;
      phase_q     <= 1'b0;
      sub_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      sg_q        <= 24'd655360;
      tg_q        <= 24'd6554;
      drag_q      <= 24'd655360;
      rest_q      <= 24'd5898;
      dt_q        <= '0;
      acc_q       <= '0;
      root_q      <= '0;
      mf2_q       <= '0;
      ef2_q       <= '0;
      t_q         <= '0;
      mom_q       <= '0;
      mom_neg_q   <= 1'b0;
      for (int j = 0; j < 3; j++) begin
        grav_q[j] <= '0;
        mp_q[j]   <= '0;
        tp_q[j]   <= '0;
        mv_q[j]   <= '0;
        tv_q[j]   <= '0;
        base_q[j] <= '0;
        bdir_q[j] <= '0;
        md_q[j]   <= '0;
        ed_q[j]   <= '0;
        ax_q[j]   <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (tssc_pkg::cfg_idx_e'(cfg_idx_i))
          tssc_pkg::CFG_SPRING_GAIN: sg_q      <= cfg_data_i[23:0];
          tssc_pkg::CFG_TORQUE_GAIN: tg_q      <= cfg_data_i[23:0];
          tssc_pkg::CFG_DRAG_RATE:   drag_q    <= cfg_data_i[23:0];
          tssc_pkg::CFG_REST_LENGTH: rest_q    <= cfg_data_i[23:0];
          tssc_pkg::CFG_GRAVITY_X:   grav_q[0] <= cfg_data_i;
          tssc_pkg::CFG_GRAVITY_Y:   grav_q[1] <= cfg_data_i;
          tssc_pkg::CFG_GRAVITY_Z:   grav_q[2] <= cfg_data_i;
          default: ;
        endcase
      end

      // The done state reloads the output register itself when it is taken.
      if (out_valid_q && m_axis_tready_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid_i) begin
            for (int j = 0; j < 3; j++) begin
              base_q[j] <= s_axis_tdata_i[32*j +: 32];
              bdir_q[j] <= s_axis_tdata_i[96 + DW*j +: DW];
            end
            dt_q    <= s_axis_tdata_i[165:150];
            idx_q   <= '0;
            seg_q   <= '0;
            phase_q <= 1'b0;
            state_q <= s_axis_tuser_i ? S_RST : S_DIFF;
          end
        end

        // Rest pose: both points laid along the base direction.
        S_RST: begin
          phase_q <= !phase_q;
          if (phase_q) begin
            mp_q[idx_q] <= tssc_pkg::add_sat(base_q[idx_q], r17);
            tp_q[idx_q] <= tssc_pkg::add_sat(tssc_pkg::add_sat(base_q[idx_q], r17), r17);
            mv_q[idx_q] <= '0;
            tv_q[idx_q] <= '0;
            if (idx_q == 2'd2) begin
              state_q <= S_DONE;
            end else begin
              idx_q <= idx_q + 2'd1;
            end
          end
        end

        // Odd segments run from the mid point to the tip, even ones from the base.
        S_DIFF: begin
          for (int j = 0; j < 3; j++) begin
            ax_q[j] <= seg_q[0] ? tssc_pkg::sub_sat(tp_q[j], mp_q[j])
                                : tssc_pkg::sub_sat(mp_q[j], base_q[j]);
          end
          acc_q   <= '0;
          idx_q   <= '0;
          phase_q <= 1'b0;
          state_q <= S_SQ;
        end

        S_SQ: begin
          phase_q <= !phase_q;
          if (phase_q) begin
            acc_q <= acc_q + prod_q[63:0];
            if (idx_q == 2'd2) begin
              idx_q   <= '0;
              state_q <= S_ROOT_GO;
            end else begin
              idx_q <= idx_q + 2'd1;
            end
          end
        end

        S_ROOT_GO: state_q <= S_ROOT_WAIT;

        S_ROOT_WAIT: begin
          if (sd_rsp.done) begin
            root_q <= sd_rsp.root;
            if (seg_q[0]) begin
              ef2_q <= f2;
            end else begin
              mf2_q <= f2;
            end
            if (sd_rsp.root == '0) begin
              // A segment of zero length takes the base direction.
              for (int j = 0; j < 3; j++) begin
                if (seg_q[0]) begin
                  ed_q[j] <= bdir_q[j];
                end else begin
                  md_q[j] <= bdir_q[j];
                end
              end
              state_q <= S_SEG_END;
            end else begin
              idx_q   <= '0;
              state_q <= S_DIV_GO;
            end
          end
        end

        S_DIV_GO: state_q <= S_DIV_WAIT;

        S_DIV_WAIT: begin
          if (sd_rsp.done) begin
            if (seg_q[0]) begin
              ed_q[idx_q] <= sd_rsp.quot;
            end else begin
              md_q[idx_q] <= sd_rsp.quot;
            end
            if (idx_q == 2'd2) begin
              state_q <= S_SEG_END;
            end else begin
              idx_q   <= idx_q + 2'd1;
              state_q <= S_DIV_GO;
            end
          end
        end

        S_SEG_END: begin
          idx_q   <= '0;
          phase_q <= 1'b0;
          sub_q   <= 1'b0;
          step_q  <= V_MSPR;
          case (seg_q)
            2'd0:    begin seg_q <= 2'd1; state_q <= S_DIFF; end
            2'd1:    state_q <= S_VEL;
            2'd2:    begin seg_q <= 2'd3; state_q <= S_DIFF; end
            default: state_q <= S_PROJ;
          endcase
        end

        // Spring, gravity and torque for each component in turn, product by product.
        S_VEL: begin
          phase_q <= !phase_q;
          if (phase_q) begin
            case (step_q)
              V_MSPR, V_TSPR: t_q <= r17;
              V_MDT: mv_q[idx_q] <= tssc_pkg::add_sat(
                                      tssc_pkg::sub_sat(mv_q[idx_q], r16), grav_q[idx_q]);
              V_TDT: tv_q[idx_q] <= tssc_pkg::add_sat(
                                      tssc_pkg::sub_sat(tv_q[idx_q], r16), grav_q[idx_q]);
              V_MTQDT: mv_q[idx_q] <= tssc_pkg::add_sat(mv_q[idx_q], r16);
              V_TTQDT: tv_q[idx_q] <= tssc_pkg::add_sat(tv_q[idx_q], r16);
              default: t_q <= r16;
            endcase
            if (step_q == V_TTQDT) begin
              step_q <= V_MSPR;
              if (idx_q == 2'd2) begin
                idx_q   <= '0;
                state_q <= S_MOM;
              end else begin
                idx_q <= idx_q + 2'd1;
              end
            end else begin
              step_q <= vstep_e'(step_q + 4'd1);
            end
          end
        end

        S_MOM: begin
          phase_q <= !phase_q;
          if (phase_q) begin
            mom_q     <= mom_w[DW-1:0];
            mom_neg_q <= mom_w[25];
            sub_q     <= 1'b0;
            state_q   <= S_DRAG;
          end
        end

        // Drag and move; drag stronger than one stops both points.
        S_DRAG: begin
          phase_q <= !phase_q;
          if (phase_q) begin
            sub_q <= !sub_q;
            if (!sub_q) begin
              mv_q[idx_q] <= dv;
              mp_q[idx_q] <= tssc_pkg::add_sat(mp_q[idx_q], dv);
            end else begin
              tv_q[idx_q] <= dv;
              tp_q[idx_q] <= tssc_pkg::add_sat(tp_q[idx_q], dv);
              if (idx_q == 2'd2) begin
                idx_q   <= '0;
                seg_q   <= 2'd2;
                state_q <= S_DIFF;
              end else begin
                idx_q <= idx_q + 2'd1;
              end
            end
          end
        end

        // The tip is placed from the unclamped mid point, then the mid point is clamped.
        S_PROJ: begin
          phase_q <= !phase_q;
          if (phase_q) begin
            sub_q <= !sub_q;
            if (!sub_q) begin
              tp_q[idx_q] <= tssc_pkg::add_sat(mp_q[idx_q], r17);
            end else begin
              mp_q[idx_q] <= tssc_pkg::add_sat(base_q[idx_q], r17);
              if (idx_q == 2'd2) begin
                state_q <= S_DONE;
              end else begin
                idx_q <= idx_q + 2'd1;
              end
            end
          end
        end

        S_DONE: begin
          if (!out_valid_q || m_axis_tready_i) begin
            out_q       <= {tp_q[2], tp_q[1], tp_q[0], mp_q[2], mp_q[1], mp_q[0]};
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

`ifndef SYNTHESIS
  a_one_item_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input accepted twice in a row");

  a_unit_answer_awaited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sd_rsp.done |-> (state_q == S_ROOT_WAIT || state_q == S_DIV_WAIT))
    else $error("root or divide result arrived outside a wait state");

  a_component_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q != 2'd3)
    else $error("component index out of range");

  a_momentum_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAG && !mom_neg_q) |-> !mom_q[DW-1])
    else $error("momentum negative without the stop flag");
`endif

endmodule

>>> verif/two_segment_spring_chain_step_top_test.sv
// Self-checking testbench for the two-segment spring chain step block.
// Depends on tssc_pkg and two_segment_spring_chain_step_top; nothing else.
module two_segment_spring_chain_step_top_test;

  timeunit 1ns;
  timeprecision 1ps;

  // One strand beat as it is sent, with fields at the block's widths.
  typedef struct {
    logic               mode;
    logic signed [31:0] base [3];
    logic signed [17:0] dir  [3];
    logic [15:0]        dt;
  } strand_beat_t;

  // One pose beat as it is expected back.
  typedef struct {
    logic signed [31:0] mid [3];
    logic signed [31:0] tip [3];
  } pose_t;

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         s_valid;
  logic         s_ready;
  logic [167:0] s_data;
  logic         s_user;
  logic         m_valid;
  logic         m_ready;
  logic [191:0] m_data;
  logic         cfg_we;
  logic [2:0]   cfg_idx;
  logic [31:0]  cfg_data;

  two_segment_spring_chain_step_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  // 20 ns clock period.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predictor copies of the registers and of the strand state.
  longint spring_k, torque_k, drag_k, rest_len;
  longint grav [3];
  longint mid_pos [3], tip_pos [3], mid_vel [3], tip_vel [3];

  pose_t pose_q [$];
  int    err_cnt   = 0;
  int    beat_cnt  = 0;
  int    pose_cnt  = 0;
  int    snd_idle  = 0;
  int    rcv_idle  = 0;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Unit direction of a segment vector; falls back to the base direction at zero length.
  function automatic longint seg_dir(input longint a [3], input longint fb [3],
                                     output longint d [3]);
    longint unsigned s;
    longint len;
    s = 0;
    for (int i = 0; i < 3; i++) s = s + longint'(a[i] * a[i]);
    len = longint'(floor_root(s));
    for (int i = 0; i < 3; i++) d[i] = (len > 0) ? (a[i] * 65536) / len : fb[i];
    return len;
  endfunction

  // Half the rest length along one direction component.
  function automatic longint half_seg(longint d);
    return clamp32((d * rest_len) >>> (tssc_pkg::FRAC_BITS + 1));
  endfunction

  function automatic pose_t strand_step(strand_beat_t b);
    longint base [3], bd [3], ax [3], md [3], ed [3], nmd [3], ned [3];
    longint dt, ml, el, mf2, ef2, t, tq, mom, off, dummy;
    pose_t p;
    for (int i = 0; i < 3; i++) begin
      base[i] = longint'(b.base[i]);
      bd[i]   = longint'(b.dir[i]);
    end
    dt = longint'({48'd0, b.dt});
    if (b.mode) begin
      for (int i = 0; i < 3; i++) begin
        off = half_seg(bd[i]);
        mid_pos[i] = clamp32(base[i] + off);
        tip_pos[i] = clamp32(mid_pos[i] + off);
        mid_vel[i] = 0;
        tip_vel[i] = 0;
      end
    end else begin
      for (int i = 0; i < 3; i++) ax[i] = clamp32(mid_pos[i] - base[i]);
      ml = seg_dir(ax, bd, md);
      for (int i = 0; i < 3; i++) ax[i] = clamp32(tip_pos[i] - mid_pos[i]);
      el = seg_dir(ax, bd, ed);
      mf2 = 2 * ml - rest_len;
      ef2 = 2 * el - rest_len;
      for (int i = 0; i < 3; i++) begin
        t = clamp32((md[i] * mf2) >>> (tssc_pkg::FRAC_BITS + 1));
        t = clamp32((t * spring_k) >>> tssc_pkg::FRAC_BITS);
        t = clamp32((t * dt) >>> tssc_pkg::DT_BITS);
        mid_vel[i] = clamp32(mid_vel[i] - t);
        t = clamp32((ed[i] * ef2) >>> (tssc_pkg::FRAC_BITS + 1));
        t = clamp32((t * spring_k) >>> tssc_pkg::FRAC_BITS);
        t = clamp32((t * dt) >>> tssc_pkg::DT_BITS);
        tip_vel[i] = clamp32(tip_vel[i] - t);
        mid_vel[i] = clamp32(mid_vel[i] + grav[i]);
        tip_vel[i] = clamp32(tip_vel[i] + grav[i]);
        tq = clamp32((bd[i] * torque_k) >>> tssc_pkg::FRAC_BITS);
        tq = clamp32((tq * dt) >>> tssc_pkg::DT_BITS);
        mid_vel[i] = clamp32(mid_vel[i] + tq);
        tq = clamp32((md[i] * torque_k) >>> tssc_pkg::FRAC_BITS);
        tq = clamp32((tq * dt) >>> tssc_pkg::DT_BITS);
        tip_vel[i] = clamp32(tip_vel[i] + tq);
      end
      mom = 65536 - ((drag_k * dt) >>> tssc_pkg::DT_BITS);
      for (int i = 0; i < 3; i++) begin
        if (mom < 0) begin
          mid_vel[i] = 0;
          tip_vel[i] = 0;
        end else begin
          mid_vel[i] = clamp32((mid_vel[i] * mom) >>> tssc_pkg::FRAC_BITS);
          tip_vel[i] = clamp32((tip_vel[i] * mom) >>> tssc_pkg::FRAC_BITS);
        end
        mid_pos[i] = clamp32(mid_pos[i] + mid_vel[i]);
        tip_pos[i] = clamp32(tip_pos[i] + tip_vel[i]);
      end
      for (int i = 0; i < 3; i++) ax[i] = clamp32(mid_pos[i] - base[i]);
      dummy = seg_dir(ax, bd, nmd);
      for (int i = 0; i < 3; i++) ax[i] = clamp32(tip_pos[i] - mid_pos[i]);
      dummy = seg_dir(ax, bd, ned);
      // The tip follows the moved mid point before the mid point is clamped.
      for (int i = 0; i < 3; i++) begin
        tip_pos[i] = clamp32(mid_pos[i] + half_seg(ned[i]));
        mid_pos[i] = clamp32(base[i] + half_seg(nmd[i]));
      end
    end
    for (int i = 0; i < 3; i++) begin
      p.mid[i] = mid_pos[i][31:0];
      p.tip[i] = tip_pos[i][31:0];
    end
    return p;
  endfunction

  // Receiver: random back-pressure on the result channel.
  always @(posedge clk_i) begin
    m_ready <= (rcv_idle == 0) || ($urandom_range(99) >= rcv_idle);
  end

  // Result checker: each pose beat against the oldest expectation.
  always @(posedge clk_i) begin
    pose_t        e;
    logic [31:0]  got;
    if (rst_ni && m_valid && m_ready) begin
      if (pose_q.size() == 0) begin
        $error("unexpected pose beat %h", m_data);
        err_cnt++;
      end else begin
        e = pose_q.pop_front();
        pose_cnt++;
        for (int i = 0; i < 3; i++) begin
          got = m_data[32*i +: 32];
          if (got !== e.mid[i]) begin
            $error("mid_%0d expected %h actual %h", i, e.mid[i], got);
            err_cnt++;
          end
          got = m_data[96 + 32*i +: 32];
          if (got !== e.tip[i]) begin
            $error("tip_%0d expected %h actual %h", i, e.tip[i], got);
            err_cnt++;
          end
        end
      end
    end
  end

  // Sends one strand beat, with a random gap first, and records its expected pose.
  task automatic send_beat(strand_beat_t b);
    if (snd_idle != 0 && $urandom_range(99) < snd_idle) begin
      s_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < snd_idle);
    end
    s_valid <= 1'b1;
    s_user  <= b.mode;
    s_data  <= {2'b00, b.dt, b.dir[2], b.dir[1], b.dir[0], b.base[2], b.base[1], b.base[0]};
    do @(posedge clk_i); while (!s_ready);
    pose_q.push_back(strand_step(b));
    beat_cnt++;
  endtask

  // Lets every pending pose come back with the sender quiet.
  task automatic drain;
    s_valid <= 1'b0;
    do @(posedge clk_i); while (pose_q.size() != 0);
    repeat (20) @(posedge clk_i);
  endtask

  // Register write; only called while the block is idle.
  task automatic write_reg(tssc_pkg::cfg_idx_e idx, logic [31:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
    case (idx)
      tssc_pkg::CFG_SPRING_GAIN: spring_k = longint'({40'd0, val[23:0]});
      tssc_pkg::CFG_TORQUE_GAIN: torque_k = longint'({40'd0, val[23:0]});
      tssc_pkg::CFG_DRAG_RATE:   drag_k   = longint'({40'd0, val[23:0]});
      tssc_pkg::CFG_REST_LENGTH: rest_len = longint'({40'd0, val[23:0]});
      tssc_pkg::CFG_GRAVITY_X:   grav[0]  = longint'(signed'(val));
      tssc_pkg::CFG_GRAVITY_Y:   grav[1]  = longint'(signed'(val));
      tssc_pkg::CFG_GRAVITY_Z:   grav[2]  = longint'(signed'(val));
      default: ;
    endcase
  endtask

  task automatic write_all(logic [23:0] sk, logic [23:0] tk, logic [23:0] dk,
                           logic [23:0] rl, logic [31:0] gx, logic [31:0] gy,
                           logic [31:0] gz);
    write_reg(tssc_pkg::CFG_SPRING_GAIN, {8'd0, sk});
    write_reg(tssc_pkg::CFG_TORQUE_GAIN, {8'd0, tk});
    write_reg(tssc_pkg::CFG_DRAG_RATE, {8'd0, dk});
    write_reg(tssc_pkg::CFG_REST_LENGTH, {8'd0, rl});
    write_reg(tssc_pkg::CFG_GRAVITY_X, gx);
    write_reg(tssc_pkg::CFG_GRAVITY_Y, gy);
    write_reg(tssc_pkg::CFG_GRAVITY_Z, gz);
  endtask

  function automatic strand_beat_t make_beat(logic m, logic signed [31:0] bx,
                                             logic signed [31:0] by, logic signed [31:0] bz,
                                             logic signed [17:0] dx, logic signed [17:0] dy,
                                             logic signed [17:0] dz, logic [15:0] dt);
    strand_beat_t b;
    b.mode = m;
    b.base[0] = bx; b.base[1] = by; b.base[2] = bz;
    b.dir[0]  = dx; b.dir[1]  = dy; b.dir[2]  = dz;
    b.dt = dt;
    return b;
  endfunction

  // Mostly small coordinates near the strand, sometimes large or extreme.
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(9))
      0:       return $urandom();
      1:       return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      2, 3:    return 32'($signed($urandom_range(16777215)) - 8388608);
      default: return 32'($signed($urandom_range(16383)) - 8192);
    endcase
  endfunction

  // Mostly unit-range direction components, sometimes the whole 18-bit range.
  function automatic logic [17:0] rand_dir();
    case ($urandom_range(9))
      0:       return 18'($urandom());
      1:       return $urandom_range(1) ? 18'sd65536 : -18'sd65536;
      default: return 18'($signed($urandom_range(131072)) - 65536);
    endcase
  endfunction

  function automatic logic [15:0] rand_dt();
    case ($urandom_range(7))
      0:       return 16'($urandom());
      1:       return $urandom_range(1) ? 16'hffff : 16'h0000;
      default: return 16'($urandom_range(4369));  // up to about a 15th of a second
    endcase
  endfunction

  // Directed beats: field extremes, dt extremes, zero-length segments, strong drag,
  // directions off unit length.
  task automatic test_directed;
    // Rest pose along +x, then steps with zero, typical and maximum dt.
    send_beat(make_beat(1'b1, 0, 0, 0, 18'sd65536, 0, 0, 16'h0000));
    send_beat(make_beat(1'b0, 0, 0, 0, 18'sd65536, 0, 0, 16'h0000));
    send_beat(make_beat(1'b0, 0, 0, 0, 18'sd65536, 0, 0, 16'd1092));
    // Maximum dt with the default drag drives momentum below zero.
    send_beat(make_beat(1'b0, 0, 0, 0, 0, -18'sd65536, 0, 16'hffff));
    // Rest pose with a zero direction collapses both segments to zero length.
    send_beat(make_beat(1'b1, 32'sd1000, -32'sd1000, 32'sd5, 0, 0, 0, 16'h1234));
    send_beat(make_beat(1'b0, 32'sd1000, -32'sd1000, 32'sd5, 0, 0, 18'sd65536, 16'd2000));
    send_beat(make_beat(1'b0, 32'sd1000, -32'sd1000, 32'sd5, 0, 18'sd65536, 0, 16'd2000));
    // Base at the extremes forces saturation everywhere.
    send_beat(make_beat(1'b1, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
                        18'sd65536, -18'sd65536, 18'sd65536, 16'hffff));
    send_beat(make_beat(1'b0, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
                        -18'sd65536, 18'sd65536, -18'sd65536, 16'd500));
    send_beat(make_beat(1'b0, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                        18'sd65536, 18'sd65536, 18'sd65536, 16'hffff));
    // Directions outside plus or minus one, used without normalization.
    send_beat(make_beat(1'b1, 0, 0, 0, 18'h1ffff, 18'h20000, 18'h1ffff, 16'd0));
    send_beat(make_beat(1'b0, 0, 0, 0, 18'h20000, 18'h1ffff, 18'h20000, 16'd3000));
    send_beat(make_beat(1'b0, 32'sd65536, 0, 0, 18'sd46341, 18'sd46341, 0, 16'd1000));
    send_beat(make_beat(1'b0, 32'sd70000, 32'sd300, -32'sd300, 18'sd46341, 0, 18'sd46341,
                        16'd1000));
  endtask

  // Register extremes: all zero, all maximum, and strong gravity both ways.
  task automatic test_config_extremes;
    drain();
    write_all(24'h0, 24'h0, 24'h0, 24'h0, 32'h0, 32'h0, 32'h0);
    send_beat(make_beat(1'b1, 32'sd100, 32'sd200, 32'sd300, 0, 0, 18'sd65536, 16'd0));
    send_beat(make_beat(1'b0, 32'sd100, 32'sd200, 32'sd300, 0, 0, 18'sd65536, 16'hffff));
    drain();
    write_all(24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff,
              32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_beat(make_beat(1'b1, 0, 0, 0, 18'sd65536, 0, 0, 16'd0));
    send_beat(make_beat(1'b0, 0, 0, 0, 18'sd65536, 0, 0, 16'd1));
    send_beat(make_beat(1'b0, 32'sd5000, 0, 0, 0, 18'sd65536, 0, 16'hffff));
    drain();
    // Low drag keeps momentum, gravity of opposite extremes.
    write_all(24'hffffff, 24'hffffff, 24'h0, 24'd5898,
              32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    send_beat(make_beat(1'b0, 0, 0, 0, 0, 0, -18'sd65536, 16'hffff));
    send_beat(make_beat(1'b0, 0, 0, 0, 0, 0, -18'sd65536, 16'h8000));
    send_beat(make_beat(1'b0, 0, 0, 0, 0, 0, -18'sd65536, 16'd1));
  endtask

  // Random phase: mostly advance steps around a wandering base, with some rest beats
  // and some unrelated noise beats. Registers change only at the start of the phase.
  task automatic test_random(int n_beats, int s_pct, int r_pct);
    strand_beat_t b;
    logic signed [31:0] bx, by, bz;
    drain();
    snd_idle = s_pct;
    rcv_idle = r_pct;
    write_reg(tssc_pkg::CFG_SPRING_GAIN, {8'd0, 24'($urandom_range(1310720))});
    write_reg(tssc_pkg::CFG_TORQUE_GAIN, {8'd0, 24'($urandom_range(65536))});
    write_reg(tssc_pkg::CFG_DRAG_RATE, {8'd0, 24'($urandom_range(1310720))});
    write_reg(tssc_pkg::CFG_REST_LENGTH, {8'd0, 24'($urandom_range(262144))});
    write_reg(tssc_pkg::CFG_GRAVITY_X, 32'($signed($urandom_range(2000)) - 1000));
    write_reg(tssc_pkg::CFG_GRAVITY_Y, 32'($signed($urandom_range(2000)) - 1000));
    write_reg(tssc_pkg::CFG_GRAVITY_Z, $urandom_range(7) == 0 ? $urandom() : 32'd0);
    bx = 0; by = 0; bz = 0;
    for (int k = 0; k < n_beats; k++) begin
      if ($urandom_range(9) == 0) begin
        // Noise: any content at all.
        b = make_beat(1'($urandom()), rand_coord(), rand_coord(), rand_coord(),
                      rand_dir(), rand_dir(), rand_dir(), 16'($urandom()));
        bx = b.base[0]; by = b.base[1]; bz = b.base[2];
      end else begin
        bx = bx + 32'($signed($urandom_range(2048)) - 1024);
        by = by + 32'($signed($urandom_range(2048)) - 1024);
        bz = bz + 32'($signed($urandom_range(2048)) - 1024);
        b = make_beat($urandom_range(14) == 0, bx, by, bz,
                      rand_dir(), rand_dir(), rand_dir(), rand_dt());
      end
      send_beat(b);
      // Once per phase the sender holds off until every pose is back.
      if (k == n_beats / 2) begin
        s_valid <= 1'b0;
        do @(posedge clk_i); while (pose_q.size() != 0);
      end
    end
  endtask

  initial begin
    rst_ni   <= 1'b0;
    s_valid  <= 1'b0;
    s_user   <= 1'b0;
    s_data   <= '0;
    cfg_we   <= 1'b0;
    cfg_idx  <= tssc_pkg::CFG_SPRING_GAIN;
    cfg_data <= '0;
    spring_k = 655360;
    torque_k = 6554;
    drag_k   = 655360;
    rest_len = 5898;
    for (int i = 0; i < 3; i++) begin
      grav[i] = 0; mid_pos[i] = 0; tip_pos[i] = 0; mid_vel[i] = 0; tip_vel[i] = 0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    snd_idle = 19;
    rcv_idle = 71;
    test_directed();
    test_config_extremes();
    test_random(600, 19, 71);
    test_random(600, 71, 19);
    test_random(610, 0, 0);

    // Wait for the last poses, then a settle period of one sequence.
    s_valid <= 1'b0;
    do @(posedge clk_i); while (pose_q.size() != 0);
    repeat (600) @(posedge clk_i);

    $display("Covered %0d strand beats and %0d pose beats over register extremes", beat_cnt,
             pose_cnt);
    $display("and three back-pressure phases; %0d mismatches.", err_cnt);
    if (err_cnt == 0 && pose_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #100_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
